/* src/video_pll_factor_search_top_assert.svh */
// ----------------------------------------------------------------------------
// Video PLL factor search - assertion macros
// Shorthand for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef VIDEO_PLL_FACTOR_SEARCH_TOP_ASSERT_SVH
`define VIDEO_PLL_FACTOR_SEARCH_TOP_ASSERT_SVH

// same-cycle implication
`define VPFS_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("vpfs assertion failed");

// next-cycle implication
`define VPFS_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("vpfs assertion failed");

`endif

/* src/vpfs_pkg.sv */
// ----------------------------------------------------------------------------
// vpfs_pkg
// Field widths, divider thresholds and divider selection.
// ----------------------------------------------------------------------------
package vpfs_pkg;

	localparam int TGT_W = 20;
	localparam int REF_W = 17;
	localparam int DIV_W = 4;

	localparam logic [TGT_W-1:0] THR_DIV11 = TGT_W'(27000);
	localparam logic [TGT_W-1:0] THR_DIV4  = TGT_W'(74250);
	localparam logic [TGT_W-1:0] THR_DIV2  = TGT_W'(148500);

	localparam logic [REF_W-1:0] REF_RESET = REF_W'(24000);

	localparam logic [DIV_W-1:0] DIV_11 = DIV_W'(11);
	localparam logic [DIV_W-1:0] DIV_4  = DIV_W'(4);
	localparam logic [DIV_W-1:0] DIV_2  = DIV_W'(2);
	localparam logic [DIV_W-1:0] DIV_1  = DIV_W'(1);
	localparam int DIV_MAX = 11;

	function automatic logic [DIV_W-1:0] pick_div(input logic [TGT_W-1:0] t);
		logic [DIV_W-1:0] d;
		if (t <= THR_DIV11) begin
			d = DIV_11;
		end else if (t <= THR_DIV4) begin
			d = DIV_4;
		end else if (t <= THR_DIV2) begin
			d = DIV_2;
		end else begin
			d = DIV_1;
		end
		return d;
	endfunction

endpackage

/* src/video_pll_factor_search_top.sv */
// done pulses when an accepted start has left the vld_s chain (length set by MAX_PREDIV/MAX_MULT).
// Throughput: one item per clock; every pre-divider has its own pipelined restoring
// dividers (one quotient bit per stage), followed by a registered min tree.
// busy stays low; the receiver cannot stall, results are never held.
// Reset: reference returns to 24000 kHz and all in-flight transfers are dropped.
// ----------------------------------------------------------------------------
// video_pll_factor_search_top
// Pipelined search for PLL pre-divider/multiplier giving the closest pixel clock at or below the target.
// ----------------------------------------------------------------------------
module video_pll_factor_search_top #(
	parameter int MAX_PREDIV = 16,
	parameter int MAX_MULT   = 128
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [vpfs_pkg::REF_W-1:0]        reference_khz,
	input  logic                              start,
	output logic                              busy,
	input  logic [vpfs_pkg::TGT_W-1:0]        target_khz,
	output logic                              done,
	output logic [$clog2(MAX_MULT+1)-1:0]     mult_n,
	output logic [$clog2(MAX_PREDIV+1)-1:0]   prediv_m,
	output logic [vpfs_pkg::DIV_W-1:0]        phy_divider,
	output logic [vpfs_pkg::TGT_W-1:0]        achieved_khz,
	output logic [vpfs_pkg::TGT_W-1:0]        shortfall_khz,
	output logic                              found
);
	import vpfs_pkg::*;

	localparam int MW     = $clog2(MAX_PREDIV+1);
	localparam int NB     = $clog2(MAX_MULT+1);
	localparam int DW     = $clog2(DIV_MAX*MAX_PREDIV+1);
	localparam int PW     = TGT_W + DW;
	localparam int LW     = REF_W + $clog2(MAX_MULT+2);
	localparam int XW0    = (PW > LW) ? PW : LW;
	localparam int XW     = (XW0 > REF_W + NB) ? XW0 : REF_W + NB;
	localparam int XRW    = REF_W + 1;
	localparam int YW     = XRW + DW;
	localparam int LS     = NB + 2 + XRW;
	localparam int LV     = $clog2(MAX_PREDIV);
	localparam int LEAVES = 1 << LV;
	localparam int LAST   = LS + 1 + LV;
	localparam int LAT    = LAST + 2;

	typedef struct packed {
		logic           ok;
		logic [NB-1:0]  n;
		logic [MW-1:0]  m;
		logic [XRW-1:0] diff;
	} cand_t;

	logic [REF_W-1:0] ref_q;
	logic [LW-1:0]    lim_q;
	logic             vld_s [LAST+1];

	logic [TGT_W-1:0] tgt_s [LAST+1];
	logic [DIV_W-1:0] div_s [LAST+1];

	logic [XW-1:0]    nrem_s [MAX_PREDIV][NB+1];
	logic [NB-1:0]    nq_s   [MAX_PREDIV][NB+1];
	logic             nok_s  [MAX_PREDIV][NB+1];
	logic [YW-1:0]    srem_s [MAX_PREDIV][XRW+1];
	logic [XRW-1:0]   sq_s   [MAX_PREDIV][XRW+1];
	logic [NB-1:0]    sn_s   [MAX_PREDIV][XRW+1];
	logic             sok_s  [MAX_PREDIV][XRW+1];
	cand_t            cand_s [LV+1][LEAVES];

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_q <= REF_RESET;
			lim_q <= LW'(LW'(REF_RESET) * LW'(MAX_MULT+1));
			for (int k = 0; k <= LAST; k++) begin
				vld_s[k] <= 1'b0;
			end
			done <= 1'b0;
		end else begin
			if (cfg_we) begin
				ref_q <= reference_khz;
			end
			lim_q <= LW'(LW'(ref_q) * LW'(MAX_MULT+1));
			vld_s[0] <= start && !busy;
			for (int k = 1; k <= LAST; k++) begin
				vld_s[k] <= vld_s[k-1];
			end
			done <= vld_s[LAST];
		end
	end

	always_ff @(posedge clk) begin
		logic [DW-1:0] d;
		logic [XW-1:0] shn;
		logic [YW-1:0] shs;
		logic          ge;
		logic          rng;
		cand_t         a;
		cand_t         b;
		cand_t         best;

		tgt_s[0] <= target_khz;
		div_s[0] <= pick_div(target_khz);
		for (int k = 1; k <= LAST; k++) begin
			tgt_s[k] <= tgt_s[k-1];
			div_s[k] <= div_s[k-1];
		end

		for (int g = 0; g < MAX_PREDIV; g++) begin
			// n = floor(m*div*target / ref), remainder kept for the shortfall
			d = DW'(DW'(g+1) * DW'(div_s[0]));
			nrem_s[g][0] <= XW'(PW'(d) * PW'(tgt_s[0]));
			nq_s[g][0]   <= '0;
			nok_s[g][0]  <= 1'b1;
			for (int i = 0; i < NB; i++) begin
				shn = XW'(ref_q) << (NB-1-i);
				ge  = nrem_s[g][i] >= shn;
				rng = (nrem_s[g][i] >= XW'(ref_q)) && (nrem_s[g][i] < XW'(lim_q));
				nrem_s[g][i+1] <= ge ? nrem_s[g][i] - shn : nrem_s[g][i];
				nq_s[g][i+1]   <= NB'({nq_s[g][i], ge});
				nok_s[g][i+1]  <= nok_s[g][i] && ((i != 0) || rng);
			end
			// shortfall = ceil(rem / (m*div))
			d = DW'(DW'(g+1) * DW'(div_s[NB+1]));
			srem_s[g][0] <= YW'(nrem_s[g][NB][XRW-1:0]) + YW'(d) - YW'(1);
			sq_s[g][0]   <= '0;
			sn_s[g][0]   <= nq_s[g][NB];
			sok_s[g][0]  <= nok_s[g][NB];
			for (int j = 0; j < XRW; j++) begin
				d   = DW'(DW'(g+1) * DW'(div_s[NB+2+j]));
				shs = YW'(d) << (XRW-1-j);
				ge  = srem_s[g][j] >= shs;
				srem_s[g][j+1] <= ge ? srem_s[g][j] - shs : srem_s[g][j];
				sq_s[g][j+1]   <= XRW'({sq_s[g][j], ge});
				sn_s[g][j+1]   <= sn_s[g][j];
				sok_s[g][j+1]  <= sok_s[g][j];
			end
		end

		for (int p = 0; p < LEAVES; p++) begin
			if (p < MAX_PREDIV) begin
				cand_s[0][p] <= '{ok: sok_s[p][XRW], n: sn_s[p][XRW], m: MW'(p+1),
					diff: sq_s[p][XRW]};
			end else begin
				cand_s[0][p] <= '0;
			end
		end
		// ties keep the left (smaller m) side
		for (int l = 0; l < LV; l++) begin
			for (int p = 0; p < (LEAVES >> (l+1)); p++) begin
				a = cand_s[l][2*p];
				b = cand_s[l][2*p+1];
				cand_s[l+1][p] <= (a.ok && (!b.ok || a.diff <= b.diff)) ? a : b;
			end
		end

		best = cand_s[LV][0];
		phy_divider <= div_s[LAST];
		found       <= best.ok;
		if (best.ok) begin
			mult_n        <= best.n;
			prediv_m      <= best.m;
			achieved_khz  <= tgt_s[LAST] - TGT_W'(best.diff);
			shortfall_khz <= TGT_W'(best.diff);
		end else begin
			mult_n        <= '0;
			prediv_m      <= '0;
			achieved_khz  <= '0;
			shortfall_khz <= '0;
		end
	end

	`include "video_pll_factor_search_top_assert.svh"

	`VPFS_ASSERT_IMP(a_latency, done, $past(start && !busy, LAT))
	`VPFS_ASSERT_IMP(a_sum, done && found, (21'(achieved_khz) + 21'(shortfall_khz)) == 21'($past(target_khz, LAT)))
	`VPFS_ASSERT_IMP(a_none, done && !found, mult_n == '0 && prediv_m == '0 && achieved_khz == '0)
	`VPFS_ASSERT_NXT(a_enter, start && !busy, vld_s[0])

endmodule

/* tb/video_pll_factor_search_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// video_pll_factor_search_checker
// Watches the command and result channels of the PLL factor search, computes
// the expected factors for every accepted target and compares them in order.
// ----------------------------------------------------------------------------
module video_pll_factor_search_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [vpfs_pkg::REF_W-1:0]  reference_khz,
	input  logic                        start,
	input  logic                        busy,
	input  logic [vpfs_pkg::TGT_W-1:0]  target_khz,
	input  logic                        done,
	input  logic [7:0]                  mult_n,
	input  logic [4:0]                  prediv_m,
	input  logic [vpfs_pkg::DIV_W-1:0]  phy_divider,
	input  logic [vpfs_pkg::TGT_W-1:0]  achieved_khz,
	input  logic [vpfs_pkg::TGT_W-1:0]  shortfall_khz,
	input  logic                        found,
	output int                          errors,
	output int                          pending
);
	import vpfs_pkg::*;

	localparam int PREDIV_LIMIT = 16;
	localparam int MULT_LIMIT = 128;

	typedef struct packed {
		logic [7:0]       n;
		logic [4:0]       m;
		logic [DIV_W-1:0] div;
		logic [TGT_W-1:0] achieved;
		logic [TGT_W-1:0] shortfall;
		logic             found;
	} pll_factors_t;

	logic [REF_W-1:0] ref_khz;
	pll_factors_t     factor_queue[$];

	function automatic pll_factors_t search_factors(logic [TGT_W-1:0] tgt,
			logic [REF_W-1:0] rk);
		pll_factors_t r;
		longint unsigned d, n, v, diff, best;
		d = (tgt <= THR_DIV11) ? 11 : (tgt <= THR_DIV4) ? 4 : (tgt <= THR_DIV2) ? 2 : 1;
		r = '0;
		r.div = DIV_W'(d);
		best = 64'h0FFFFFFF;
		if (rk != 0) begin
			for (int m = 1; m <= PREDIV_LIMIT; m++) begin
				n = (m * d * tgt) / rk;
				if (n >= 1 && n <= MULT_LIMIT) begin
					v = ((rk * n) / m) / d;
					diff = (v <= tgt) ? tgt - v : 0;
					if (diff < best) begin
						best = diff;
						r.n = 8'(n);
						r.m = 5'(m);
						r.achieved = TGT_W'(v);
						r.shortfall = TGT_W'(diff);
						r.found = 1'b1;
					end
				end
			end
		end
		return r;
	endfunction

	assign pending = factor_queue.size();

	always @(posedge clk or negedge arst_n) begin
		pll_factors_t want, got;
		if (!arst_n) begin
			ref_khz <= REF_RESET;
			errors <= 0;
			factor_queue.delete();
		end else begin
			if (done) begin
				got = '{mult_n, prediv_m, phy_divider, achieved_khz, shortfall_khz, found};
				if (factor_queue.size() == 0) begin
					errors <= errors + 1;
					if (errors < 10)
						$display("unexpected result transfer %p", got);
				end else begin
					want = factor_queue.pop_front();
					if (want !== got) begin
						errors <= errors + 1;
						if (errors < 10)
							$display("mismatch: expected %p, got %p", want, got);
					end
				end
			end
			if (start && !busy)
				factor_queue.push_back(search_factors(target_khz, ref_khz));
			if (cfg_we)
				ref_khz <= reference_khz;
		end
	end
endmodule

/* tb/video_pll_factor_search_top_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// video_pll_factor_search_top_tb
// Drives directed and random pixel clock targets under several reference
// clocks in bursts with gaps; the checker predicts and compares each result.
// ----------------------------------------------------------------------------
module video_pll_factor_search_top_tb;
	import vpfs_pkg::*;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [REF_W-1:0] reference_khz;
	logic             start;
	logic             busy;
	logic [TGT_W-1:0] target_khz;
	logic             done;
	logic [7:0]       mult_n;
	logic [4:0]       prediv_m;
	logic [DIV_W-1:0] phy_divider;
	logic [TGT_W-1:0] achieved_khz;
	logic [TGT_W-1:0] shortfall_khz;
	logic             found;
	int               errors;
	int               pending;
	int               cycle_count;

	video_pll_factor_search_top uut (.*);

	video_pll_factor_search_checker chk (.*);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count > 400000) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	task automatic send_target(logic [TGT_W-1:0] t);
		start <= 1'b1;
		target_khz <= t;
		do @(posedge clk); while (busy);
		if ($urandom_range(0, 5) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	task automatic drain_and_write(logic [REF_W-1:0] rk);
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		cfg_we <= 1'b1;
		reference_khz <= rk;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [TGT_W-1:0] rand_target();
		case ($urandom_range(0, 5))
			0: return TGT_W'($urandom_range(0, 30000));
			1: return TGT_W'($urandom_range(26990, 27010));
			2: return TGT_W'($urandom_range(74240, 74260));
			3: return TGT_W'($urandom_range(148490, 148510));
			4: return TGT_W'($urandom_range(0, 1000000));
			default: return TGT_W'($urandom);
		endcase
	endfunction

	initial begin
		logic [REF_W-1:0] refs[6];
		logic [TGT_W-1:0] directed[$];
		refs = '{REF_W'(1000), REF_W'(100000), REF_W'(27000), REF_W'(0),
			REF_W'(131071), REF_W'(24000)};
		directed = '{0, 1, 27000, 27001, 74250, 74251, 148500, 148500 + 1, 1000000,
			20'hFFFFF, 25175, 65000, 108000, 297000, 594000, 24000, 12000, 3};
		arst_n = 1'b0;
		cfg_we = 1'b0;
		reference_khz = '0;
		start = 1'b0;
		target_khz = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed[i]) send_target(directed[i]);
		for (int phase = 0; phase < 6; phase++) begin
			drain_and_write(phase == 5 ? REF_W'($urandom_range(1000, 100000)) : refs[phase]);
			for (int i = 0; i < 90; ) begin
				repeat ($urandom_range(1, 12)) begin
					send_target(rand_target());
					i++;
				end
				start <= 1'b0;
				if ($urandom_range(0, 2) != 0)
					repeat ($urandom_range(1, 20)) @(posedge clk);
			end
		end
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule
